FILE: sv/lup_decompose_invert_solve_macros.svh
// assertion macros for the lu decomposition block
`ifndef LUP_DECOMPOSE_INVERT_SOLVE_MACROS_SVH
`define LUP_DECOMPOSE_INVERT_SOLVE_MACROS_SVH

// same-cycle implication
`define LUP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lup check failed");

// next-cycle implication
`define LUP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lup check failed");

`endif

FILE: sv/lup_pkg.sv
// shared constants for the lu decomposition block
`default_nettype none
package lup_pkg;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd2;

	localparam logic [1:0] OP_INVERSE = 2'd0;
	localparam logic [1:0] OP_SOLVE   = 2'd1;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;
endpackage
`default_nettype wire

FILE: sv/lup_mem.sv
// synchronous one-write one-read memory with registered read data
`default_nettype none
module lup_mem #(
	parameter int W = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/lup_div.sv
// bit-serial saturating fixed-point divider
`default_nettype none
module lup_div #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] dividend,
	input  wire logic signed [31:0] divisor,
	output logic                    done,
	output logic signed [31:0]      quot
);
	import lup_pkg::*;

	localparam int NW = 32 + FRACTION_BITS;
	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q, fin_q, done_q, neg_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   num_q;
	logic [31:0]     den_q, rem_q;
	logic signed [31:0] quot_q;
	logic [31:0]     a_mag, b_mag;
	logic [32:0]     rem_sh;
	logic            ge;
	logic            big;

	assign a_mag  = dividend[31] ? (32'd0 - dividend) : dividend;
	assign b_mag  = divisor[31] ? (32'd0 - divisor) : divisor;
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign big    = num_q[NW-1:31] != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (divisor == 32'sd0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNTW'(NW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {a_mag, {FRACTION_BITS{1'b0}}};
			den_q <= b_mag;
			rem_q <= '0;
			neg_q <= dividend[31] ^ divisor[31];
			if (dividend > 32'sd0) begin
				quot_q <= Q_MAX;
			end else if (dividend < 32'sd0) begin
				quot_q <= Q_MIN;
			end else begin
				quot_q <= 32'sd0;
			end
		end else if (busy_q) begin
			rem_q <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
			num_q <= {num_q[NW-2:0], ge};
		end else if (fin_q) begin
			if (neg_q) begin
				quot_q <= big ? Q_MIN : 32'(32'd0 - num_q[31:0]);
			end else begin
				quot_q <= big ? Q_MAX : num_q[31:0];
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

FILE: sv/lup_decompose_invert_solve.sv
// lu decomposition with partial pivoting: inverse, linear solve or determinant
//
// s_t* takes the matrix elements in row-major order, one item a cycle, then in
// solve mode the right-hand-side elements. cfg_* writes operation, matrix size
// and tolerance; any write restarts loading. Writes belong in idle time.
// After the last item the block stops taking input and runs the elimination
// and then the substitutions, or for the determinant the product of the pivots,
// from two memories with registered reads (coefficients and results).
// Divisions run in the bit-serial divider, which dominates the multiply-subtracts:
// about n*n/2 divisions in elimination and n*n (inverse) or n (solve) in back
// substitution.
// Results leave on m_t* from one output register; tlast marks the last one and
// tuser flags a singular run, which gives a single zero result.
// A stalled receiver holds the sequencer at the output step; input is taken
// again once the last result sits in the output register.
// Reset clears the control state and the row order to identity; memory
// contents are not cleared and are always written before being read.
`default_nettype none
module lup_decompose_invert_solve #(
	parameter int MAX_DIM = 8,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // element_value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // result_value
	output logic             m_tuser,   // singular
	output logic             m_tlast,   // last_of_run
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [lup_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	import lup_pkg::*;

	localparam int RW = $clog2(MAX_DIM);
	localparam int CW = $clog2(MAX_DIM + 1);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = $clog2(DEPTH);
	localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRACTION_BITS;

	localparam logic [4:0] S_LOAD   = 5'd0;
	localparam logic [4:0] S_PS_RD  = 5'd1;
	localparam logic [4:0] S_PS_CMP = 5'd2;
	localparam logic [4:0] S_PS_END = 5'd3;
	localparam logic [4:0] S_EL_RD  = 5'd4;
	localparam logic [4:0] S_EL_DIV = 5'd5;
	localparam logic [4:0] S_EL_DW  = 5'd6;
	localparam logic [4:0] S_EU_RD1 = 5'd7;
	localparam logic [4:0] S_EU_RD2 = 5'd8;
	localparam logic [4:0] S_EU_M1  = 5'd9;
	localparam logic [4:0] S_EU_WR  = 5'd10;
	localparam logic [4:0] S_EL_NX  = 5'd11;
	localparam logic [4:0] S_I_NX   = 5'd12;
	localparam logic [4:0] S_DT_RD  = 5'd13;
	localparam logic [4:0] S_DT_MUL = 5'd14;
	localparam logic [4:0] S_DT_Q   = 5'd15;
	localparam logic [4:0] S_DT_OUT = 5'd16;
	localparam logic [4:0] S_TC_INI = 5'd17;
	localparam logic [4:0] S_FW_I   = 5'd18;
	localparam logic [4:0] S_MA_RD  = 5'd19;
	localparam logic [4:0] S_MA_MUL = 5'd20;
	localparam logic [4:0] S_MA_Q   = 5'd21;
	localparam logic [4:0] S_MA_SUB = 5'd22;
	localparam logic [4:0] S_FW_WR  = 5'd23;
	localparam logic [4:0] S_BW_I   = 5'd24;
	localparam logic [4:0] S_BW_LD  = 5'd25;
	localparam logic [4:0] S_BW_DRD = 5'd26;
	localparam logic [4:0] S_BW_DIV = 5'd27;
	localparam logic [4:0] S_BW_DW  = 5'd28;
	localparam logic [4:0] S_OUT_RD = 5'd29;
	localparam logic [4:0] S_OUT_LD = 5'd30;
	localparam logic [4:0] S_SING   = 5'd31;

	function automatic logic [AW-1:0] caddr(input logic [RW-1:0] r, input logic [RW-1:0] c);
		caddr = AW'(int'(r) * MAX_DIM + int'(c));
	endfunction

	function automatic logic signed [31:0] qmul(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p >>> FRACTION_BITS;
		if (p[63] && (p[FRACTION_BITS-1:0] != '0)) begin
			t = t + 64'sd1;
		end
		if (t > 64'sd2147483647) begin
			qmul = Q_MAX;
		end else if (t < -64'sd2147483648) begin
			qmul = Q_MIN;
		end else begin
			qmul = t[31:0];
		end
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			qsub = d[32] ? Q_MIN : Q_MAX;
		end else begin
			qsub = d[31:0];
		end
	endfunction

	logic [4:0]    state_q;
	logic [1:0]    op_q;
	logic [3:0]    size_q;
	logic [30:0]   tol_q;
	logic [CW-1:0] ld_row_q, ld_col_q;
	logic          ld_rhs_q;
	logic [CW-1:0] i_q, j_q, k_q, pick_q;
	logic [32:0]   best_q;
	logic          par_q, bw_q;
	logic [RW-1:0] ro_q [MAX_DIM];
	logic          out_valid_q, out_sing_q, out_last_q;
	logic signed [31:0] out_data_q;

	logic signed [31:0] piv_q, f_q, acc_q, qm_s2;
	logic signed [63:0] prod_s1;
	logic signed [31:0] rhs_q [MAX_DIM];

	logic [CW-1:0] n, cols;
	logic          solve_mode, s_acc, out_free;
	logic [RW-1:0] ro_i, ro_j, ro_k;
	logic [AW-1:0] cm_raddr, cm_waddr, rm_raddr, rm_waddr;
	logic          cm_we, rm_we;
	logic [31:0]   cm_wdata, rm_wdata, cm_rdata, rm_rdata;
	logic signed [31:0] cm_rd, rm_rd, mul_a, mul_b, init_v;
	logic [32:0]   mag;
	logic          div_start, div_done;
	logic signed [31:0] div_a, div_b, div_q;
	logic          last_out;

	always_comb begin
		if (size_q == 4'd0) begin
			n = CW'(1);
		end else if (int'(size_q) > MAX_DIM) begin
			n = CW'(MAX_DIM);
		end else begin
			n = size_q[CW-1:0];
		end
	end

	assign solve_mode = op_q == OP_SOLVE;
	assign cols     = solve_mode ? CW'(1) : n;
	assign s_tready = state_q == S_LOAD;
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || m_tready;
	assign ro_i     = ro_q[i_q[RW-1:0]];
	assign ro_j     = ro_q[j_q[RW-1:0]];
	assign ro_k     = ro_q[k_q[RW-1:0]];
	assign cm_rd    = cm_rdata;
	assign rm_rd    = rm_rdata;
	assign mag      = cm_rd[31] ? (33'd0 - {cm_rd[31], cm_rd}) : {1'b0, cm_rd};
	assign last_out = (i_q + 1'b1 == n) && (j_q + 1'b1 == cols);

	function automatic logic [AW-1:0] raddr(input logic sv, input logic [RW-1:0] x,
			input logic [RW-1:0] col);
		raddr = sv ? caddr('0, x) : caddr(x, col);
	endfunction

	always_comb begin
		unique case (state_q)
			S_PS_RD:  cm_raddr = caddr(ro_k, i_q[RW-1:0]);
			S_EL_RD:  cm_raddr = caddr(ro_j, i_q[RW-1:0]);
			S_EU_RD1: cm_raddr = caddr(ro_i, k_q[RW-1:0]);
			S_EU_RD2: cm_raddr = caddr(ro_j, k_q[RW-1:0]);
			S_DT_RD:  cm_raddr = caddr(ro_i, i_q[RW-1:0]);
			S_MA_RD:  cm_raddr = caddr(ro_i, k_q[RW-1:0]);
			S_BW_DRD: cm_raddr = caddr(ro_i, i_q[RW-1:0]);
			default:  cm_raddr = '0;
		endcase
		unique case (state_q)
			S_MA_RD:  rm_raddr = raddr(solve_mode, k_q[RW-1:0], j_q[RW-1:0]);
			default:  rm_raddr = raddr(solve_mode, i_q[RW-1:0], j_q[RW-1:0]);
		endcase
		cm_we    = 1'b0;
		cm_waddr = caddr(ld_row_q[RW-1:0], ld_col_q[RW-1:0]);
		cm_wdata = s_tdata;
		if (state_q == S_LOAD) begin
			cm_we = s_acc && !ld_rhs_q;
		end else if (state_q == S_EL_DW) begin
			cm_we    = div_done;
			cm_waddr = caddr(ro_j, i_q[RW-1:0]);
			cm_wdata = div_q;
		end else if (state_q == S_EU_WR) begin
			cm_we    = 1'b1;
			cm_waddr = caddr(ro_j, k_q[RW-1:0]);
			cm_wdata = qsub(acc_q, qm_s2);
		end
		rm_waddr = raddr(solve_mode, i_q[RW-1:0], j_q[RW-1:0]);
		rm_we    = (state_q == S_FW_WR) || (state_q == S_BW_DW && div_done);
		rm_wdata = (state_q == S_FW_WR) ? acc_q : div_q;
	end

	always_comb begin
		unique case (state_q)
			S_EU_RD2: begin
				mul_a = f_q;
				mul_b = cm_rd;
			end
			S_DT_MUL: begin
				mul_a = acc_q;
				mul_b = cm_rd;
			end
			default: begin
				mul_a = cm_rd;
				mul_b = rm_rd;
			end
		endcase
		div_start = (state_q == S_EL_DIV) || (state_q == S_BW_DIV);
		div_a     = (state_q == S_EL_DIV) ? cm_rd : acc_q;
		div_b     = (state_q == S_EL_DIV) ? piv_q : cm_rd;
		if (solve_mode) begin
			init_v = rhs_q[ro_i];
		end else begin
			init_v = (CW'(ro_i) == j_q) ? Q_ONE : 32'sd0;
		end
	end

	lup_mem #(.W(32), .DEPTH(DEPTH)) u_coef (
		.clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
		.raddr(cm_raddr), .rdata(cm_rdata)
	);

	lup_mem #(.W(32), .DEPTH(DEPTH)) u_res (
		.clk(clk), .we(rm_we), .waddr(rm_waddr), .wdata(rm_wdata),
		.raddr(rm_raddr), .rdata(rm_rdata)
	);

	lup_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quot(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			op_q        <= OP_INVERSE;
			size_q      <= 4'd8;
			tol_q       <= 31'd66;
			ld_row_q    <= '0;
			ld_col_q    <= '0;
			ld_rhs_q    <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			pick_q      <= '0;
			best_q      <= '0;
			par_q       <= 1'b0;
			bw_q        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int g = 0; g < MAX_DIM; g++) begin
				ro_q[g] <= RW'(g);
			end
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (s_acc) begin
						if (!ld_rhs_q) begin
							if (ld_col_q + 1'b1 == n) begin
								ld_col_q <= '0;
								if (ld_row_q + 1'b1 == n) begin
									ld_row_q <= '0;
									if (solve_mode) begin
										ld_rhs_q <= 1'b1;
									end else begin
										state_q <= S_PS_RD;
									end
								end else begin
									ld_row_q <= ld_row_q + 1'b1;
								end
							end else begin
								ld_col_q <= ld_col_q + 1'b1;
							end
						end else if (ld_row_q + 1'b1 == n) begin
							ld_row_q <= '0;
							ld_rhs_q <= 1'b0;
							state_q  <= S_PS_RD;
						end else begin
							ld_row_q <= ld_row_q + 1'b1;
						end
						i_q    <= '0;
						k_q    <= '0;
						pick_q <= '0;
						best_q <= '0;
						par_q  <= 1'b0;
						for (int g = 0; g < MAX_DIM; g++) begin
							ro_q[g] <= RW'(g);
						end
					end
				end
				S_PS_RD: state_q <= S_PS_CMP;
				S_PS_CMP: begin
					if (mag > best_q) begin
						best_q <= mag;
						pick_q <= k_q;
					end
					if (k_q + 1'b1 < n) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_PS_RD;
					end else begin
						state_q <= S_PS_END;
					end
				end
				S_PS_END: begin
					if (best_q < {2'b00, tol_q}) begin
						state_q <= S_SING;
					end else begin
						if (pick_q != i_q) begin
							ro_q[i_q[RW-1:0]]    <= ro_q[pick_q[RW-1:0]];
							ro_q[pick_q[RW-1:0]] <= ro_i;
							par_q <= !par_q;
						end
						j_q     <= i_q + 1'b1;
						state_q <= (i_q + 1'b1 < n) ? S_EL_RD : S_I_NX;
					end
				end
				S_EL_RD:  state_q <= S_EL_DIV;
				S_EL_DIV: state_q <= S_EL_DW;
				S_EL_DW: begin
					if (div_done) begin
						k_q     <= i_q + 1'b1;
						state_q <= S_EU_RD1;
					end
				end
				S_EU_RD1: state_q <= S_EU_RD2;
				S_EU_RD2: state_q <= S_EU_M1;
				S_EU_M1:  state_q <= S_EU_WR;
				S_EU_WR: begin
					if (k_q + 1'b1 < n) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_EU_RD1;
					end else begin
						state_q <= S_EL_NX;
					end
				end
				S_EL_NX: begin
					if (j_q + 1'b1 < n) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_EL_RD;
					end else begin
						state_q <= S_I_NX;
					end
				end
				S_I_NX: begin
					if (i_q + 1'b1 < n) begin
						i_q     <= i_q + 1'b1;
						k_q     <= i_q + 1'b1;
						pick_q  <= i_q + 1'b1;
						best_q  <= '0;
						state_q <= S_PS_RD;
					end else if (op_q == OP_INVERSE || op_q == OP_SOLVE) begin
						j_q     <= '0;
						state_q <= S_TC_INI;
					end else begin
						i_q     <= '0;
						state_q <= S_DT_RD;
					end
				end
				S_DT_RD:  state_q <= S_DT_MUL;
				S_DT_MUL: begin
					if (i_q == '0) begin
						if (i_q + 1'b1 < n) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_DT_RD;
						end else begin
							state_q <= S_DT_OUT;
						end
					end else begin
						state_q <= S_DT_Q;
					end
				end
				S_DT_Q: begin
					if (i_q + 1'b1 < n) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_DT_RD;
					end else begin
						state_q <= S_DT_OUT;
					end
				end
				S_DT_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_LOAD;
					end
				end
				S_TC_INI: begin
					i_q     <= '0;
					bw_q    <= 1'b0;
					state_q <= S_FW_I;
				end
				S_FW_I: begin
					k_q     <= '0;
					state_q <= (i_q == '0) ? S_FW_WR : S_MA_RD;
				end
				S_MA_RD:  state_q <= S_MA_MUL;
				S_MA_MUL: state_q <= S_MA_Q;
				S_MA_Q:   state_q <= S_MA_SUB;
				S_MA_SUB: begin
					if (!bw_q) begin
						if (k_q + 1'b1 < i_q) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_MA_RD;
						end else begin
							state_q <= S_FW_WR;
						end
					end else if (k_q + 1'b1 < n) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_MA_RD;
					end else begin
						state_q <= S_BW_DRD;
					end
				end
				S_FW_WR: begin
					if (i_q + 1'b1 < n) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_FW_I;
					end else begin
						bw_q    <= 1'b1;
						state_q <= S_BW_I;
					end
				end
				S_BW_I: state_q <= S_BW_LD;
				S_BW_LD: begin
					if (i_q + 1'b1 < n) begin
						k_q     <= i_q + 1'b1;
						state_q <= S_MA_RD;
					end else begin
						state_q <= S_BW_DRD;
					end
				end
				S_BW_DRD: state_q <= S_BW_DIV;
				S_BW_DIV: state_q <= S_BW_DW;
				S_BW_DW: begin
					if (div_done) begin
						if (i_q == '0) begin
							if (j_q + 1'b1 < cols) begin
								j_q     <= j_q + 1'b1;
								state_q <= S_TC_INI;
							end else begin
								j_q     <= '0;
								state_q <= S_OUT_RD;
							end
						end else begin
							i_q     <= i_q - 1'b1;
							state_q <= S_BW_I;
						end
					end
				end
				S_OUT_RD: state_q <= S_OUT_LD;
				S_OUT_LD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (last_out) begin
							state_q <= S_LOAD;
						end else begin
							if (j_q + 1'b1 < cols) begin
								j_q <= j_q + 1'b1;
							end else begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end
							state_q <= S_OUT_RD;
						end
					end
				end
				S_SING: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
			if (cfg_valid) begin
				ld_row_q <= '0;
				ld_col_q <= '0;
				ld_rhs_q <= 1'b0;
				unique case (cfg_index)
					REG_OPERATION: op_q   <= cfg_data[1:0];
					REG_SIZE:      size_q <= cfg_data[3:0];
					REG_TOLERANCE: tol_q  <= cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		qm_s2   <= qmul(prod_s1);
		if (state_q == S_LOAD && s_acc && ld_rhs_q) begin
			rhs_q[ld_row_q[RW-1:0]] <= s_tdata;
		end
		case (state_q)
			S_LOAD:   piv_q <= 32'sd0;
			S_I_NX:   piv_q <= 32'sd0;
			S_PS_CMP: begin
				if (mag > best_q) begin
					piv_q <= cm_rd;
				end
			end
			S_EL_DW:  f_q   <= div_q;
			S_EU_M1:  acc_q <= cm_rd;
			S_DT_MUL: begin
				if (i_q == '0) begin
					acc_q <= cm_rd;
				end
			end
			S_DT_Q:   acc_q <= qmul(prod_s1);
			S_FW_I:   acc_q <= init_v;
			S_MA_SUB: acc_q <= qsub(acc_q, qm_s2);
			S_BW_LD:  acc_q <= rm_rd;
			default: ;
		endcase
		if (out_free) begin
			if (state_q == S_DT_OUT) begin
				out_data_q <= par_q ? ((acc_q == Q_MIN) ? Q_MAX : -acc_q) : acc_q;
				out_sing_q <= 1'b0;
				out_last_q <= 1'b1;
			end else if (state_q == S_OUT_LD) begin
				out_data_q <= rm_rd;
				out_sing_q <= 1'b0;
				out_last_q <= last_out;
			end else if (state_q == S_SING) begin
				out_data_q <= 32'sd0;
				out_sing_q <= 1'b1;
				out_last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sing_q;
	assign m_tlast  = out_last_q;
endmodule
`default_nettype wire

FILE: sv/lup_chk.sv
// port-level checks for the lu decomposition block
`default_nettype none
`include "lup_decompose_invert_solve_macros.svh"
module lup_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);
	// a singular item is the lone zero result of its run
	`LUP_ASSERT_IMP(a_sing_last, m_tvalid && m_tuser, m_tlast && (m_tdata == 32'd0))
	// results in the middle of a run keep the input closed
	`LUP_ASSERT_IMP(a_mid_no_input, m_tvalid && !m_tlast, !s_tready)
	// a waiting item keeps its flags
	`LUP_ASSERT_NXT(a_hold_flags, m_tvalid && !m_tready, $stable(m_tuser) && $stable(m_tlast))
	`LUP_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind lup_decompose_invert_solve lup_chk u_lup_chk (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
